[design/scpc_pkg.sv]
// ----------------------------------------------------------------------------
// scpc_pkg: shared types and constants of the servo pulse command controller
// Command and status payloads, command and drive-state codes, register
// indexes and reset values, and the request types of the serial units.
// ----------------------------------------------------------------------------
package scpc_pkg;

  // Command codes
  localparam logic [2:0] OP_ON          = 3'd0;
  localparam logic [2:0] OP_OFF         = 3'd1;
  localparam logic [2:0] OP_EXECUTE     = 3'd2;
  localparam logic [2:0] OP_STOP        = 3'd3;
  localparam logic [2:0] OP_RESET_ALARM = 3'd4;
  localparam logic [2:0] OP_ESTOP       = 3'd5;
  localparam logic [2:0] OP_POLL        = 3'd6;
  localparam logic [2:0] OP_SET_DIR     = 3'd7;

  // Drive states
  localparam logic [2:0] RS_IDLE    = 3'd0;
  localparam logic [2:0] RS_READY   = 3'd1;
  localparam logic [2:0] RS_RUNNING = 3'd2;
  localparam logic [2:0] RS_INPOS   = 3'd3;
  localparam logic [2:0] RS_ALARM   = 3'd4;
  localparam logic [2:0] RS_ESTOP   = 3'd5;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 29;
  localparam logic [CFG_IDX_W-1:0] CFG_PPR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DFLT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FMAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TCLK  = 3'd4;

  // Register widths and reset values
  localparam int PPR_W   = 25;
  localparam int RATED_W = 16;
  localparam int DFLT_W  = 22;
  localparam int FREQ_W  = 24;
  localparam int TCLK_W  = 29;
  localparam logic [PPR_W-1:0]   PPR_RESET   = 25'd8388608;
  localparam logic [RATED_W-1:0] RATED_RESET = 16'd3000;
  localparam logic [DFLT_W-1:0]  DFLT_RESET  = 22'd100000;
  localparam logic [FREQ_W-1:0]  FMAX_RESET  = 24'd4000000;
  localparam logic [TCLK_W-1:0]  TCLK_RESET  = 29'd168000000;
  localparam logic [15:0]        PERIOD_RESET  = 16'd1679;
  localparam logic [15:0]        COMPARE_RESET = 16'd840;

  // Serial multiplier: A times B, B taken one bit a cycle
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 16;
  localparam int PROD_W    = 42;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  // Serial divider: one quotient bit a cycle, dividend aligned to the MSB
  localparam int DVD_W     = 42;
  localparam int DSR_W     = 25;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  localparam logic [DSR_W-1:0]     SEC_PER_MIN = 25'd60;
  localparam logic [MUL_B_W-1:0]   MS_PER_SEC  = 16'd1000;
  localparam logic [DIV_CNT_W-1:0] RPM_DIV_STEPS  = 6'd41;
  localparam logic [DIV_CNT_W-1:0] TCLK_DIV_STEPS = 6'd29;
  localparam logic [DIV_CNT_W-1:0] MS_DIV_STEPS   = 6'd42;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        direction;
    logic [15:0] speed_rpm;
    logic [31:0] target_pulses;
    logic        ready_pin;
    logic        in_position_pin;
    logic        alarm_pin;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  drive_state;
    logic        enable_out;
    logic        direction_out;
    logic        pulse_active;
    logic [15:0] timer_prescale;
    logic [15:0] timer_period;
    logic [15:0] timer_compare;
    logic [31:0] run_time_ms;
  } rsp_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                 start;
    logic [DVD_W-1:0]     dividend;
    logic [DSR_W-1:0]     divisor;
    logic [DIV_CNT_W-1:0] count;
  } div_req_t;

endpackage

[design/scpc_mul.sv]
// ----------------------------------------------------------------------------
// scpc_mul: bit-serial shift-add multiplier
// Takes one multiplier bit per cycle, LSB first; pulses done with the product.
// ----------------------------------------------------------------------------
module scpc_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  scpc_pkg::mul_req_t           req,
  output logic                         done,
  output logic [scpc_pkg::PROD_W-1:0]  prod
);

  logic                             busy;
  logic [scpc_pkg::MUL_CNT_W-1:0]   cnt;
  logic [scpc_pkg::PROD_W-1:0]      a_sh;
  logic [scpc_pkg::MUL_B_W-1:0]     b_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= scpc_pkg::MUL_CNT_W'(scpc_pkg::MUL_B_W);
      end else if (busy) begin
        cnt <= cnt - scpc_pkg::MUL_CNT_W'(1);
        if (cnt == scpc_pkg::MUL_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Add the shifted multiplicand where the multiplier bit is set
  always_ff @(posedge clk) begin
    if (req.start) begin
      prod <= '0;
      a_sh <= scpc_pkg::PROD_W'(req.a);
      b_sh <= req.b;
    end else if (busy) begin
      if (b_sh[0]) begin
        prod <= prod + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

endmodule

[design/scpc_div.sv]
// ----------------------------------------------------------------------------
// scpc_div: restoring bit-serial divider
// Produces one quotient bit per cycle, count bits in all; pulses done at the end.
// ----------------------------------------------------------------------------
module scpc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  scpc_pkg::div_req_t          req,
  output logic                        done,
  output logic [scpc_pkg::DVD_W-1:0]  quo
);

  logic                             busy;
  logic [scpc_pkg::DIV_CNT_W-1:0]   cnt;
  logic [scpc_pkg::DVD_W-1:0]       dvd;
  logic [scpc_pkg::DSR_W-1:0]       dsr;
  logic [scpc_pkg::DSR_W-1:0]       rem;
  logic [scpc_pkg::DSR_W:0]         trial;
  logic [scpc_pkg::DSR_W:0]         diff;
  logic                             ge;

  assign trial = {rem, dvd[scpc_pkg::DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.count;
      end else if (busy) begin
        cnt <= cnt - scpc_pkg::DIV_CNT_W'(1);
        if (cnt == scpc_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift in the next dividend bit, subtract when the divisor fits
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= ge ? diff[scpc_pkg::DSR_W-1:0] : trial[scpc_pkg::DSR_W-1:0];
      quo <= {quo[scpc_pkg::DVD_W-2:0], ge};
    end
  end

endmodule

[design/servo_pulse_command_controller_core.sv]
// ----------------------------------------------------------------------------
// servo_pulse_command_controller_core: pulse/direction servo command controller
// Applies one drive command at a time and answers with one status transfer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : command channel (valid/ready). One command per transfer; in_ready
//           is high only while no command is being worked on.
//   out_* : status channel (valid/ready). Exactly one status transfer per
//           command, held in an output register until the receiver takes it.
//   cfg_* : register writes (index, data), always ready; write only while the
//           block has no command outstanding.
//   Sequencing: a command other than a started execute goes from decode
//   straight to the emit step. An execute runs a sequence on one bit-serial
//   multiplier and one bit-serial divider (one bit per cycle each): rpm to
//   frequency, timer setup, run time, then the emit step.
//   Throughput: one command at a time; the next command is taken in the cycle
//   after the status is loaded into the output register.
//   Reset: drive state idle, outputs off, timer period 1679 / compare 840,
//   registers at their reset values. A stalled receiver holds the status and
//   the next command finishes its work, then waits to load its status.
// ----------------------------------------------------------------------------
module servo_pulse_command_controller_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  scpc_pkg::cmd_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output scpc_pkg::rsp_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_FMUL   = 4'd2;
  localparam logic [3:0] S_FDIV   = 4'd3;
  localparam logic [3:0] S_FCHK   = 4'd4;
  localparam logic [3:0] S_QDIV   = 4'd5;
  localparam logic [3:0] S_PMUL   = 4'd6;
  localparam logic [3:0] S_PDIV   = 4'd7;
  localparam logic [3:0] S_TGT    = 4'd8;
  localparam logic [3:0] S_TMUL   = 4'd9;
  localparam logic [3:0] S_TDIV   = 4'd10;
  localparam logic [3:0] S_EMIT   = 4'd11;

  // Configuration registers
  logic [scpc_pkg::PPR_W-1:0]   ppr;
  logic [scpc_pkg::RATED_W-1:0] rated;
  logic [scpc_pkg::DFLT_W-1:0]  dflt;
  logic [scpc_pkg::FREQ_W-1:0]  fmax;
  logic [scpc_pkg::TCLK_W-1:0]  tclk;

  // Drive state
  logic [2:0]  run_state, run_state_next;
  logic        en_lvl, en_lvl_next;
  logic        dir_lvl, dir_lvl_next;
  logic        pulse_run, pulse_run_next;
  logic [15:0] pre_r, pre_r_next;
  logic [15:0] per_r, per_r_next;
  logic [15:0] cmp_r, cmp_r_next;
  logic [2:0]  poll_state;

  // Sequencer and working registers
  logic [3:0]                   st, st_next;
  scpc_pkg::cmd_t               cmd;
  logic                         exec_go, exec_go_next;
  logic                         run_ok, run_ok_next;
  logic [scpc_pkg::FREQ_W-1:0]  freq, freq_next;
  logic [15:0]                  pre_w, pre_w_next;
  logic [15:0]                  per_w, per_w_next;
  logic [15:0]                  cmp_w, cmp_w_next;
  logic [31:0]                  ms_w, ms_w_next;
  logic [scpc_pkg::TCLK_W-1:0]  q;
  logic                         emit;

  // Serial units
  scpc_pkg::mul_req_t           mreq;
  scpc_pkg::div_req_t           dreq;
  logic                         mul_done;
  logic [scpc_pkg::PROD_W-1:0]  mul_prod;
  logic                         div_done;
  logic [scpc_pkg::DVD_W-1:0]   div_quo;

  scpc_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mul_done),
    .prod (mul_prod)
  );

  scpc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (div_done),
    .quo  (div_quo)
  );

  assign in_ready  = (st == S_IDLE);
  assign cfg_ready = 1'b1;
  assign emit      = (st == S_EMIT) && (!out_valid || out_ready);
  assign q         = div_quo[scpc_pkg::TCLK_W-1:0];

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      ppr   <= scpc_pkg::PPR_RESET;
      rated <= scpc_pkg::RATED_RESET;
      dflt  <= scpc_pkg::DFLT_RESET;
      fmax  <= scpc_pkg::FMAX_RESET;
      tclk  <= scpc_pkg::TCLK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        scpc_pkg::CFG_PPR:   ppr   <= cfg_data[scpc_pkg::PPR_W-1:0];
        scpc_pkg::CFG_RATED: rated <= cfg_data[scpc_pkg::RATED_W-1:0];
        scpc_pkg::CFG_DFLT:  dflt  <= cfg_data[scpc_pkg::DFLT_W-1:0];
        scpc_pkg::CFG_FMAX:  fmax  <= cfg_data[scpc_pkg::FREQ_W-1:0];
        scpc_pkg::CFG_TCLK:  tclk  <= cfg_data[scpc_pkg::TCLK_W-1:0];
        default: ;
      endcase
    end
  end

  // Command sequence: decode, then for an execute rpm -> frequency, timer setup, run time
  always_comb begin
    st_next      = st;
    exec_go_next = exec_go;
    run_ok_next  = run_ok;
    freq_next    = freq;
    pre_w_next   = pre_w;
    per_w_next   = per_w;
    cmp_w_next   = cmp_w;
    ms_w_next    = ms_w;
    mreq         = '0;
    dreq         = '0;
    case (st)
      S_IDLE: begin
        if (in_valid) begin
          st_next = S_DECODE;
        end
      end
      S_DECODE: begin
        exec_go_next = 1'b0;
        run_ok_next  = 1'b0;
        ms_w_next    = '0;
        if (cmd.opcode == scpc_pkg::OP_EXECUTE && run_state != scpc_pkg::RS_IDLE &&
            run_state != scpc_pkg::RS_ALARM) begin
          exec_go_next = 1'b1;
          if (cmd.speed_rpm != '0 && cmd.speed_rpm <= rated) begin
            mreq.start = 1'b1;
            mreq.a     = scpc_pkg::MUL_A_W'(ppr);
            mreq.b     = cmd.speed_rpm;
            st_next    = S_FMUL;
          end else begin
            freq_next = scpc_pkg::FREQ_W'(dflt);
            st_next   = S_FCHK;
          end
        end else begin
          st_next = S_EMIT;
        end
      end
      S_FMUL: begin
        // speed * ppr fits 41 bits; divide by 60
        if (mul_done) begin
          dreq.start    = 1'b1;
          dreq.dividend = {mul_prod[scpc_pkg::PROD_W-2:0], 1'b0};
          dreq.divisor  = scpc_pkg::SEC_PER_MIN;
          dreq.count    = scpc_pkg::RPM_DIV_STEPS;
          st_next       = S_FDIV;
        end
      end
      S_FDIV: begin
        if (div_done) begin
          freq_next = (div_quo > scpc_pkg::DVD_W'(fmax)) ? fmax
                                                         : div_quo[scpc_pkg::FREQ_W-1:0];
          st_next   = S_FCHK;
        end
      end
      S_FCHK: begin
        if (freq != '0 && freq <= fmax) begin
          run_ok_next   = 1'b1;
          dreq.start    = 1'b1;
          dreq.dividend = {tclk, (scpc_pkg::DVD_W - scpc_pkg::TCLK_W)'(0)};
          dreq.divisor  = scpc_pkg::DSR_W'(freq);
          dreq.count    = scpc_pkg::TCLK_DIV_STEPS;
          st_next       = S_QDIV;
        end else begin
          st_next = S_TGT;
        end
      end
      S_QDIV: begin
        if (div_done) begin
          if (q == '0) begin
            // Timer clock below the pulse frequency
            pre_w_next = '0;
            per_w_next = '0;
            cmp_w_next = '0;
            st_next    = S_TGT;
          end else if (q > scpc_pkg::TCLK_W'(65536)) begin
            // Prescaler is q / 65536; redo the period with (pre + 1) * freq
            pre_w_next = 16'(q[scpc_pkg::TCLK_W-1:16]);
            mreq.start = 1'b1;
            mreq.a     = scpc_pkg::MUL_A_W'(freq);
            mreq.b     = 16'(q[scpc_pkg::TCLK_W-1:16]) + 16'd1;
            st_next    = S_PMUL;
          end else begin
            pre_w_next = '0;
            per_w_next = 16'(q - scpc_pkg::TCLK_W'(1));
            cmp_w_next = q[16:1];
            st_next    = S_TGT;
          end
        end
      end
      S_PMUL: begin
        // (pre + 1) * freq stays below 2^25 since pre * freq <= tclk / 65536
        if (mul_done) begin
          dreq.start    = 1'b1;
          dreq.dividend = {tclk, (scpc_pkg::DVD_W - scpc_pkg::TCLK_W)'(0)};
          dreq.divisor  = mul_prod[scpc_pkg::DSR_W-1:0];
          dreq.count    = scpc_pkg::TCLK_DIV_STEPS;
          st_next       = S_PDIV;
        end
      end
      S_PDIV: begin
        if (div_done) begin
          if (q == '0) begin
            per_w_next = '0;
          end else if (q > scpc_pkg::TCLK_W'(65536)) begin
            per_w_next = 16'hFFFF;
          end else begin
            per_w_next = 16'(q - scpc_pkg::TCLK_W'(1));
          end
          cmp_w_next = (q > scpc_pkg::TCLK_W'(131071)) ? 16'hFFFF : q[16:1];
          st_next    = S_TGT;
        end
      end
      S_TGT: begin
        if (cmd.target_pulses != '0) begin
          if (freq == '0) begin
            ms_w_next = '1;
            st_next   = S_EMIT;
          end else begin
            mreq.start = 1'b1;
            mreq.a     = cmd.target_pulses;
            mreq.b     = scpc_pkg::MS_PER_SEC;
            st_next    = S_TMUL;
          end
        end else begin
          st_next = S_EMIT;
        end
      end
      S_TMUL: begin
        if (mul_done) begin
          dreq.start    = 1'b1;
          dreq.dividend = mul_prod;
          dreq.divisor  = scpc_pkg::DSR_W'(freq);
          dreq.count    = scpc_pkg::MS_DIV_STEPS;
          st_next       = S_TDIV;
        end
      end
      S_TDIV: begin
        if (div_done) begin
          ms_w_next = (div_quo[scpc_pkg::DVD_W-1:32] != '0) ? '1 : div_quo[31:0];
          st_next   = S_EMIT;
        end
      end
      S_EMIT: begin
        // Hold until the output register is free
        if (!out_valid || out_ready) begin
          st_next = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  // Drive state after the command
  always_comb begin
    run_state_next = run_state;
    en_lvl_next    = en_lvl;
    dir_lvl_next   = dir_lvl;
    pulse_run_next = pulse_run;
    pre_r_next     = pre_r;
    per_r_next     = per_r;
    cmp_r_next     = cmp_r;
    poll_state     = run_state;
    case (cmd.opcode)
      scpc_pkg::OP_ON: begin
        en_lvl_next = 1'b1;
        if (cmd.ready_pin) begin
          run_state_next = scpc_pkg::RS_READY;
        end
      end
      scpc_pkg::OP_OFF: begin
        pulse_run_next = 1'b0;
        en_lvl_next    = 1'b0;
        run_state_next = scpc_pkg::RS_IDLE;
      end
      scpc_pkg::OP_EXECUTE: begin
        if (exec_go) begin
          dir_lvl_next = cmd.direction;
          if (run_ok) begin
            pulse_run_next = 1'b1;
            run_state_next = scpc_pkg::RS_RUNNING;
            pre_r_next     = pre_w;
            per_r_next     = per_w;
            cmp_r_next     = cmp_w;
          end
          // Targeted move completes at once
          if (cmd.target_pulses != '0) begin
            pulse_run_next = 1'b0;
            run_state_next = scpc_pkg::RS_INPOS;
          end
        end
      end
      scpc_pkg::OP_STOP: begin
        pulse_run_next = 1'b0;
        if (run_state == scpc_pkg::RS_RUNNING) begin
          run_state_next = scpc_pkg::RS_READY;
        end
      end
      scpc_pkg::OP_RESET_ALARM: run_state_next = scpc_pkg::RS_READY;
      scpc_pkg::OP_ESTOP: begin
        pulse_run_next = 1'b0;
        en_lvl_next    = 1'b0;
        run_state_next = scpc_pkg::RS_ESTOP;
      end
      scpc_pkg::OP_POLL: begin
        if (cmd.alarm_pin) begin
          run_state_next = scpc_pkg::RS_ALARM;
        end else begin
          if (cmd.in_position_pin && run_state != scpc_pkg::RS_RUNNING) begin
            poll_state = scpc_pkg::RS_INPOS;
          end
          run_state_next = (cmd.ready_pin && poll_state == scpc_pkg::RS_IDLE) ?
                           scpc_pkg::RS_READY : poll_state;
        end
      end
      scpc_pkg::OP_SET_DIR: dir_lvl_next = cmd.direction;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      exec_go   <= 1'b0;
      run_ok    <= 1'b0;
      out_valid <= 1'b0;
      run_state <= scpc_pkg::RS_IDLE;
      en_lvl    <= 1'b0;
      dir_lvl   <= 1'b0;
      pulse_run <= 1'b0;
      pre_r     <= '0;
      per_r     <= scpc_pkg::PERIOD_RESET;
      cmp_r     <= scpc_pkg::COMPARE_RESET;
    end else begin
      st      <= st_next;
      exec_go <= exec_go_next;
      run_ok  <= run_ok_next;
      if (emit) begin
        out_valid <= 1'b1;
        run_state <= run_state_next;
        en_lvl    <= en_lvl_next;
        dir_lvl   <= dir_lvl_next;
        pulse_run <= pulse_run_next;
        pre_r     <= pre_r_next;
        per_r     <= per_r_next;
        cmp_r     <= cmp_r_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= in_data;
    end
    freq  <= freq_next;
    pre_w <= pre_w_next;
    per_w <= per_w_next;
    cmp_w <= cmp_w_next;
    ms_w  <= ms_w_next;
    if (emit) begin
      out_data.drive_state    <= run_state_next;
      out_data.enable_out     <= en_lvl_next;
      out_data.direction_out  <= dir_lvl_next;
      out_data.pulse_active   <= pulse_run_next;
      out_data.timer_prescale <= pre_r_next;
      out_data.timer_period   <= per_r_next;
      out_data.timer_compare  <= cmp_r_next;
      out_data.run_time_ms    <= ms_w;
    end
  end

  // Assertions
  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> st == S_DECODE)
    else $error("command transfer did not start decode");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid && st == S_IDLE)
    else $error("status not loaded on emit");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (st == S_FDIV || st == S_QDIV || st == S_PDIV || st == S_TDIV))
    else $error("divider finished outside a divide step");

  a_mul_done_expected: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (st == S_FMUL || st == S_PMUL || st == S_TMUL))
    else $error("multiplier finished outside a multiply step");

  a_compare_half: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.timer_compare <= 16'd32768)
    else $error("timer compare above half range");

endmodule
